// ===== hdl/adw_pkg.sv =====
// Shared types and constants for the Adam weight update pipeline.
package adw_pkg;

  localparam int unsigned IdxW      = 12;
  localparam int unsigned DataW     = 32;
  localparam int unsigned Depth     = 4096;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned BiasSteps = 32;
  localparam int unsigned RootSteps = 28;
  localparam int unsigned QuotSteps = 56;
  localparam int unsigned CfgW      = 24;

  localparam logic [23:0] LrReset  = 24'd16777;
  localparam logic [15:0] B1Reset  = 16'd58982;
  localparam logic [15:0] B2Reset  = 16'd65470;
  localparam logic [15:0] EpsReset = 16'd1;

  typedef enum logic [1:0] {
    CFG_LR  = 2'd0,
    CFG_B1  = 2'd1,
    CFG_B2  = 2'd2,
    CFG_EPS = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [IdxW-1:0]         param_index;
    logic signed [DataW-1:0] gradient;
    logic signed [DataW-1:0] weight_in;
    logic                    new_step;
  } in_word_t;

  typedef struct packed {
    logic [IdxW-1:0]         index_out;
    logic signed [DataW-1:0] weight_out;
    logic                    saturated;
  } out_word_t;

  typedef struct packed {
    logic [IdxW-1:0]         idx;
    logic signed [DataW-1:0] w;
  } tag_t;

  typedef struct packed {
    tag_t                    tag;
    logic signed [DataW-1:0] g;
    logic [31:0]             p1;
    logic [31:0]             p2;
    logic                    corr;
  } mom_in_t;

  typedef struct packed {
    tag_t                    tag;
    logic                    corr;
    logic [31:0]             p1;
    logic [31:0]             p2;
    logic signed [31:0]      m;
    logic [31:0]             v;
  } mom_out_t;

  typedef struct packed {
    tag_t        tag;
    logic        corr;
    logic        neg;
    logic [31:0] mmag;
    logic [31:0] v;
    logic [32:0] c1;
    logic [32:0] c2;
    logic [31:0] rm;
    logic [31:0] qm;
    logic [31:0] rv;
    logic [31:0] qv;
    logic        ovm;
    logic        ovv;
  } bias_st_t;

  typedef struct packed {
    tag_t        tag;
    logic        neg;
    logic [31:0] mq;
    logic [31:0] x;
    logic [29:0] rem;
    logic [27:0] root;
  } root_st_t;

  typedef struct packed {
    tag_t        tag;
    logic        neg;
    logic [31:0] d;
    logic [28:0] den;
    logic [28:0] r;
    logic [55:0] q;
  } quot_st_t;

endpackage

// ===== hdl/adam_weight_update.sv =====
// Throughput: one word per cycle while the skid stage is empty and no clearing pass runs;
// a word whose index matches one of the three words still in the moment update waits
// for the store write-back.
// Reset: registers take their reset values, step powers return to one, then a clearing
// pass over all 4096 entries zeroes both moment stores; no word is accepted during it.
// A one-word skid stage behind the output register holds a word arriving in a stall.
module adam_weight_update import adw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_word_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_word_t       out_data_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  logic [23:0] lr_q;
  logic [15:0] b1_q, b2_q, eps_q;
  logic [31:0] p1_q, p2_q, p1_nx, p2_nx;
  logic [47:0] p1_prod, p2_prod;
  logic        started_q;

  logic     adv, acc, hazard, busy;
  mom_in_t  mom_in;
  logic     mom_v, bias_v, root_v, quot_v;
  mom_out_t mom_out;
  bias_st_t bias_out;
  root_st_t root_out;
  quot_st_t quot_out;

  logic        p_v_q;
  tag_t        p_tag_q;
  logic        p_neg_q;
  logic [55:0] pa, pa_q;
  logic [47:0] pb, pb_q;
  logic [56:0] stp;
  logic signed [58:0] ws, sv, nw;
  out_word_t   res, out_q, skid_q;
  logic        out_v_q, skid_v_q, take;

  assign adv        = ~skid_v_q;
  assign in_stall_o = skid_v_q | busy | hazard;
  assign acc        = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= LrReset;
      b1_q  <= B1Reset;
      b2_q  <= B2Reset;
      eps_q <= EpsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_LR:  lr_q  <= cfg_data_i[23:0];
        CFG_B1:  b1_q  <= cfg_data_i[15:0];
        CFG_B2:  b2_q  <= cfg_data_i[15:0];
        CFG_EPS: eps_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // running decay powers, Q0.32 with all ones standing for one
  always_comb begin
    p1_prod = 48'(p1_q) * 48'(b1_q);
    p2_prod = 48'(p2_q) * 48'(b2_q);
    p1_nx   = p1_prod[47:16];
    p2_nx   = p2_prod[47:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q      <= '1;
      p2_q      <= '1;
      started_q <= 1'b0;
    end else if (acc && in_data_i.new_step) begin
      p1_q      <= p1_nx;
      p2_q      <= p2_nx;
      started_q <= 1'b1;
    end
  end

  always_comb begin
    mom_in.tag.idx = in_data_i.param_index;
    mom_in.tag.w   = in_data_i.weight_in;
    mom_in.g       = in_data_i.gradient;
    mom_in.p1      = in_data_i.new_step ? p1_nx : p1_q;
    mom_in.p2      = in_data_i.new_step ? p2_nx : p2_q;
    mom_in.corr    = started_q | in_data_i.new_step;
  end

  adw_moment u_moment (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .acc_i     (acc),
    .in_i      (mom_in),
    .b1_i      (b1_q),
    .b2_i      (b2_q),
    .chk_idx_i (in_data_i.param_index),
    .hazard_o  (hazard),
    .busy_o    (busy),
    .valid_o   (mom_v),
    .out_o     (mom_out)
  );

  adw_bias u_bias (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (mom_v),
    .in_i    (mom_out),
    .valid_o (bias_v),
    .out_o   (bias_out)
  );

  adw_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (bias_v),
    .in_i    (bias_out),
    .valid_o (root_v),
    .out_o   (root_out)
  );

  adw_quot u_quot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (root_v),
    .in_i    (root_out),
    .eps_i   (eps_q),
    .valid_o (quot_v),
    .out_o   (quot_out)
  );

  // lr times quotient, split at the binary point
  always_comb begin
    pa = 56'(lr_q) * 56'(quot_out.q[55:24]);
    pb = 48'(lr_q) * 48'(quot_out.q[23:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (adv) begin
      p_v_q <= quot_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_tag_q <= quot_out.tag;
      p_neg_q <= quot_out.neg;
      pa_q    <= pa;
      pb_q    <= pb;
    end
  end

  always_comb begin
    stp = 57'(pa_q) + 57'(pb_q[47:24]);
    ws  = 59'(p_tag_q.w);
    sv  = $signed({2'b00, stp});
    nw  = p_neg_q ? (ws + sv) : (ws - sv);
    res.index_out = p_tag_q.idx;
    if (!nw[58] && (nw[57:31] != '0)) begin
      res.weight_out = 32'sh7FFF_FFFF;
      res.saturated  = 1'b1;
    end else if (nw[58] && (nw[57:31] != '1)) begin
      res.weight_out = 32'sh8000_0000;
      res.saturated  = 1'b1;
    end else begin
      res.weight_out = nw[31:0];
      res.saturated  = 1'b0;
    end
  end

  assign take = out_v_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || take) begin
      out_v_q <= p_v_q;
    end else if (p_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (!out_v_q || take) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/adw_moment.sv =====
// Moment stores with read, three-stage moment update and write-back.
module adw_moment import adw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            acc_i,
  input  mom_in_t         in_i,
  input  logic [15:0]     b1_i,
  input  logic [15:0]     b2_i,
  input  logic [IdxW-1:0] chk_idx_i,
  output logic            hazard_o,
  output logic            busy_o,
  output logic            valid_o,
  output mom_out_t        out_o
);

  logic signed [31:0] m_mem [Depth];
  logic [31:0]        v_mem [Depth];

  logic [AddrW-1:0] clr_addr_q;
  logic             clr_busy_q;
  logic [2:0]       vld_q;
  mom_in_t          s1_q, s2_q, s3_q;

  logic signed [31:0] mo_q, m3_q;
  logic [31:0]        vo_q, vo2_q;
  logic [16:0]        om1, om2;
  logic [31:0]        gmag;
  logic signed [48:0] pm1, pm1_q;
  logic signed [49:0] pm2, pm2_q;
  logic [63:0]        gg, gg_q;
  logic signed [50:0] msum;
  logic signed [34:0] msh;
  logic signed [31:0] m_sat;
  logic [39:0]        gsq_w;
  logic [31:0]        gsq;
  logic [47:0]        pv1, pv1_q;
  logic [48:0]        pv2, pv2_q;
  logic [49:0]        vsum;
  logic [31:0]        v_sat;
  logic               we;
  logic [AddrW-1:0]   wa;
  logic signed [31:0] m_wd;
  logic [31:0]        v_wd;

  assign om1 = 17'h1_0000 - {1'b0, b1_i};
  assign om2 = 17'h1_0000 - {1'b0, b2_i};

  // stage 1: products
  always_comb begin
    gmag = s1_q.g[31] ? (32'd0 - $unsigned(s1_q.g)) : $unsigned(s1_q.g);
    gg   = 64'(gmag) * 64'(gmag);
    pm1  = 49'($signed({1'b0, b1_i})) * 49'(mo_q);
    pm2  = 50'($signed({1'b0, om1})) * 50'(s1_q.g);
  end

  // stage 2: first moment, squared gradient, second moment products
  always_comb begin
    msum = 51'(pm1_q) + 51'(pm2_q);
    msh  = $signed(msum[50:16]);
    if (!msh[34] && (msh[33:31] != 3'b000)) begin
      m_sat = 32'sh7FFF_FFFF;
    end else if (msh[34] && (msh[33:31] != 3'b111)) begin
      m_sat = 32'sh8000_0000;
    end else begin
      m_sat = msh[31:0];
    end
    gsq_w = gg_q[63:24];
    gsq   = (|gsq_w[39:32]) ? 32'hFFFF_FFFF : gsq_w[31:0];
    pv1   = 48'(b2_i) * 48'(vo2_q);
    pv2   = 49'(om2) * 49'(gsq);
  end

  // stage 3: second moment
  always_comb begin
    vsum  = 50'(pv1_q) + 50'(pv2_q);
    v_sat = (|vsum[49:48]) ? 32'hFFFF_FFFF : vsum[47:16];
  end

  always_comb begin
    we   = clr_busy_q | (adv_i & vld_q[2]);
    wa   = clr_busy_q ? clr_addr_q : s3_q.tag.idx[AddrW-1:0];
    m_wd = clr_busy_q ? 32'sd0 : m3_q;
    v_wd = clr_busy_q ? 32'd0 : v_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      vld_q      <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
        if (clr_addr_q == AddrW'(Depth - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (adv_i) begin
        vld_q <= {vld_q[1:0], acc_i};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_q <= in_i;
      mo_q <= m_mem[in_i.tag.idx[AddrW-1:0]];
      vo_q <= v_mem[in_i.tag.idx[AddrW-1:0]];
    end
    if (adv_i) begin
      s2_q  <= s1_q;
      pm1_q <= pm1;
      pm2_q <= pm2;
      gg_q  <= gg;
      vo2_q <= vo_q;
      s3_q  <= s2_q;
      m3_q  <= m_sat;
      pv1_q <= pv1;
      pv2_q <= pv2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      m_mem[wa] <= m_wd;
      v_mem[wa] <= v_wd;
    end
  end

  // an element still being updated must not be read again
  assign hazard_o = (vld_q[0] && (s1_q.tag.idx == chk_idx_i))
                 || (vld_q[1] && (s2_q.tag.idx == chk_idx_i))
                 || (vld_q[2] && (s3_q.tag.idx == chk_idx_i));
  assign busy_o   = clr_busy_q;
  assign valid_o  = vld_q[2];

  always_comb begin
    out_o.tag  = s3_q.tag;
    out_o.corr = s3_q.corr;
    out_o.p1   = s3_q.p1;
    out_o.p2   = s3_q.p2;
    out_o.m    = m3_q;
    out_o.v    = v_sat;
  end

endmodule

// ===== hdl/adw_bias.sv =====
// Bias correction: two restoring dividers, one quotient bit per stage.
module adw_bias import adw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     valid_i,
  input  mom_out_t in_i,
  output logic     valid_o,
  output bias_st_t out_o
);

  bias_st_t             st_q [BiasSteps+1];
  logic [BiasSteps:0]   vld_q;
  bias_st_t             ld;

  always_comb begin
    ld.tag  = in_i.tag;
    ld.corr = in_i.corr;
    ld.neg  = in_i.m[31];
    ld.mmag = in_i.m[31] ? (32'd0 - $unsigned(in_i.m)) : $unsigned(in_i.m);
    ld.v    = in_i.v;
    ld.c1   = 33'h1_0000_0000 - {1'b0, in_i.p1};
    ld.c2   = 33'h1_0000_0000 - {1'b0, in_i.p2};
    ld.rm   = ld.mmag;
    ld.qm   = '0;
    ld.rv   = in_i.v;
    ld.qv   = '0;
    ld.ovm  = 1'b0;
    ld.ovv  = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[BiasSteps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q[0] <= ld;
    end
  end

  for (genvar k = 0; k < BiasSteps; k++) begin : gen_step
    bias_st_t    nxt;
    logic [32:0] rm2, rv2;
    logic        gem, gev;

    always_comb begin
      rm2      = {st_q[k].rm, 1'b0};
      rv2      = {st_q[k].rv, 1'b0};
      gem      = rm2 >= st_q[k].c1;
      gev      = rv2 >= st_q[k].c2;
      nxt      = st_q[k];
      nxt.rm   = gem ? 32'(rm2 - st_q[k].c1) : rm2[31:0];
      nxt.rv   = gev ? 32'(rv2 - st_q[k].c2) : rv2[31:0];
      nxt.qm   = {st_q[k].qm[30:0], gem};
      nxt.qv   = {st_q[k].qv[30:0], gev};
      // quotient of 2^32 or more: dividend already not below divisor
      if (k == 0) begin
        nxt.ovm = {1'b0, st_q[k].rm} >= st_q[k].c1;
        nxt.ovv = {1'b0, st_q[k].rv} >= st_q[k].c2;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        st_q[k+1] <= nxt;
      end
    end
  end

  assign valid_o = vld_q[BiasSteps];
  assign out_o   = st_q[BiasSteps];

endmodule

// ===== hdl/adw_root.sv =====
// Saturation of the corrected moments and bit-serial square root.
module adw_root import adw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     valid_i,
  input  bias_st_t in_i,
  output logic     valid_o,
  output root_st_t out_o
);

  root_st_t           st_q [RootSteps+1];
  logic [RootSteps:0] vld_q;
  root_st_t           ld;
  logic [31:0]        mq, vq;

  always_comb begin
    if (in_i.corr) begin
      if (in_i.ovm) begin
        mq = in_i.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (in_i.neg) begin
        mq = (in_i.qm > 32'h8000_0000) ? 32'h8000_0000 : in_i.qm;
      end else begin
        mq = (in_i.qm > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : in_i.qm;
      end
      vq = in_i.ovv ? 32'hFFFF_FFFF : in_i.qv;
    end else begin
      mq = in_i.mmag;
      vq = in_i.v;
    end
    ld.tag  = in_i.tag;
    ld.neg  = in_i.neg;
    ld.mq   = mq;
    ld.x    = vq;
    ld.rem  = '0;
    ld.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[RootSteps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q[0] <= ld;
    end
  end

  // radicand is vhat scaled by 2^24: pairs from vhat, then zero pairs
  for (genvar k = 0; k < RootSteps; k++) begin : gen_step
    root_st_t    nxt;
    logic [31:0] rs, trial;
    logic        ge;

    always_comb begin
      rs       = {st_q[k].rem, st_q[k].x[31:30]};
      trial    = {2'b00, st_q[k].root, 2'b01};
      ge       = rs >= trial;
      nxt      = st_q[k];
      nxt.rem  = ge ? 30'(rs - trial) : rs[29:0];
      nxt.root = {st_q[k].root[26:0], ge};
      nxt.x    = {st_q[k].x[29:0], 2'b00};
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        st_q[k+1] <= nxt;
      end
    end
  end

  assign valid_o = vld_q[RootSteps];
  assign out_o   = st_q[RootSteps];

endmodule

// ===== hdl/adw_quot.sv =====
// Quotient m/(root+eps) in Q32.24, restoring divider one bit per stage.
module adw_quot import adw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  root_st_t    in_i,
  input  logic [15:0] eps_i,
  output logic        valid_o,
  output quot_st_t    out_o
);

  quot_st_t           st_q [QuotSteps+1];
  logic [QuotSteps:0] vld_q;
  quot_st_t           ld;
  logic [15:0]        eps_e;

  always_comb begin
    eps_e  = (eps_i == 16'd0) ? 16'd1 : eps_i;
    ld.tag = in_i.tag;
    ld.neg = in_i.neg;
    ld.d   = in_i.mq;
    ld.den = 29'(in_i.root) + 29'(eps_e);
    ld.r   = '0;
    ld.q   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[QuotSteps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q[0] <= ld;
    end
  end

  // dividend is m scaled by 2^24: its bits first, then zeros
  for (genvar k = 0; k < QuotSteps; k++) begin : gen_step
    quot_st_t    nxt;
    logic [29:0] r2;
    logic        ge;

    always_comb begin
      r2    = {st_q[k].r, st_q[k].d[31]};
      ge    = r2 >= {1'b0, st_q[k].den};
      nxt   = st_q[k];
      nxt.r = ge ? 29'(r2 - {1'b0, st_q[k].den}) : r2[28:0];
      nxt.d = {st_q[k].d[30:0], 1'b0};
      nxt.q = {st_q[k].q[54:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        st_q[k+1] <= nxt;
      end
    end
  end

  assign valid_o = vld_q[QuotSteps];
  assign out_o   = st_q[QuotSteps];

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the Adam weight update pipeline: directed and random words against a predictor.
module tb import adw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Latency   = 123;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned HoldLen   = 400;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  in_word_t        in_data_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_word_t       out_data_o;
  logic            cfg_we_i = 1'b0;
  logic [1:0]      cfg_index_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  adam_weight_update uut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [23:0] lr_q;
  logic [15:0] b1_q, b2_q, eps_q;
  logic signed [31:0] m_store [Depth];
  logic [31:0] v_store [Depth];
  logic [31:0] steps_q, p1_q, p2_q;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int unsigned errors = 0, accepted_in = 0, checked_out = 0, idle_cycles = 0;
  bit   hold_req = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_cnt = 0;
  bit   send_hold = 1'b1;
  int   burst_left = 0, gap_left = 0;

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic out_word_t predict_weight(in_word_t w);
    out_word_t res;
    logic [11:0] a;
    logic signed [63:0] g, m, nw, b1, b2, prod;
    logic [63:0] gm, gsq, v, mmag, vhat, den, q, stp, e;
    bit neg, sat;
    a = 12'(w.param_index % Depth);
    g = 64'(w.gradient);
    b1 = 64'(b1_q);
    b2 = 64'(b2_q);
    sat = 0;
    if (w.new_step) begin
      if (steps_q != 32'hFFFF_FFFF) steps_q++;
      p1_q = 32'((64'(p1_q) * 64'(b1_q)) >> 16);
      p2_q = 32'((64'(p2_q) * 64'(b2_q)) >> 16);
    end
    prod = b1 * 64'(m_store[a]) + (65536 - b1) * g;
    m = prod >>> 16;  // arithmetic shift is a floor
    if (m > 64'sd2147483647) m = 64'sd2147483647;
    if (m < -64'sd2147483648) m = -64'sd2147483648;
    m_store[a] = 32'(m);
    gm = g < 0 ? 64'(-g) : 64'(g);
    gsq = (gm * gm) >> 24;
    if (gsq > 64'hFFFF_FFFF) gsq = 64'hFFFF_FFFF;
    v = (64'(b2_q) * 64'(v_store[a]) + 64'(65536 - b2) * gsq) >> 16;
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    v_store[a] = 32'(v);
    neg = m < 0;
    mmag = neg ? 64'(-m) : 64'(m);
    vhat = v;
    if (steps_q != 0) begin
      mmag = (mmag << 32) / ((64'd1 << 32) - 64'(p1_q));
      vhat = (vhat << 32) / ((64'd1 << 32) - 64'(p2_q));
    end
    if (neg) begin
      if (mmag > 64'h8000_0000) mmag = 64'h8000_0000;
    end else if (mmag > 64'h7FFF_FFFF) begin
      mmag = 64'h7FFF_FFFF;
    end
    if (vhat > 64'hFFFF_FFFF) vhat = 64'hFFFF_FFFF;
    e = eps_q == 0 ? 64'd1 : 64'(eps_q);
    den = isqrt(vhat << 24) + e;
    q = (mmag << 24) / den;
    stp = 64'(lr_q) * (q >> 24) + ((64'(lr_q) * (q & 64'hFF_FFFF)) >> 24);
    nw = neg ? 64'(w.weight_in) + $signed(stp) : 64'(w.weight_in) - $signed(stp);
    if (nw > 64'sd2147483647) begin nw = 64'sd2147483647; sat = 1; end
    if (nw < -64'sd2147483648) begin nw = -64'sd2147483648; sat = 1; end
    res.index_out = w.param_index;
    res.weight_out = 32'(nw);
    res.saturated = sat;
    return res;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_words.push_back(predict_weight(in_data_i));
        accepted_in++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) gap_left--;
        if (!send_hold && gap_left == 0 && pending_words.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_words.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern and monitor
  int stall_phase = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word index=%0d", out_data_o.index_out);
          errors++;
        end else begin
          out_word_t ex;
          ex = expected_words.pop_front();
          if (ex.index_out !== out_data_o.index_out) begin
            $error("index_out exp %0d got %0d", ex.index_out, out_data_o.index_out);
            errors++;
          end
          if (ex.weight_out !== out_data_o.weight_out) begin
            $error("weight_out exp %0h got %0h", ex.weight_out, out_data_o.weight_out);
            errors++;
          end
          if (ex.saturated !== out_data_o.saturated) begin
            $error("saturated exp %0b got %0b", ex.saturated, out_data_o.saturated);
            errors++;
          end
          checked_out++;
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      stall_phase++;
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        hold_cnt++;
        if (hold_cnt >= HoldLen) hold_done = 1'b1;
      end
      else if (stall_phase % 200 < 60) out_stall_i <= 1'b0;
      else out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles > IdleLimit) begin
      $display("timeout: no handshake for %0d cycles", IdleLimit);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(cfg_index_e r, logic [CfgW-1:0] d);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    unique case (r)
      CFG_LR:  lr_q  = d[23:0];
      CFG_B1:  b1_q  = d[15:0];
      CFG_B2:  b2_q  = d[15:0];
      CFG_EPS: eps_q = d[15:0];
    endcase
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && !in_valid_i && expected_words.size() == 0);
    send_hold = 1'b1;
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  function automatic in_word_t rand_word(int idx_span, bit step);
    in_word_t w;
    w.param_index = (idx_span == 0) ? 12'($urandom) : 12'($urandom_range(0, idx_span));
    case ($urandom_range(0, 3))
      0: w.gradient = $signed($urandom);
      1: w.gradient = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      2: w.gradient = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      default: w.gradient = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
    w.weight_in = $urandom_range(0, 5) == 0 ?
                  ($urandom_range(0, 1) ? 32'sh7FFF_FF00 : 32'sh8000_0100) : $signed($urandom);
    w.new_step = step;
    return w;
  endfunction

  task automatic random_phase(int n);
    int span;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) span = $urandom_range(0, 1) ? 15 : 0;
      pending_words.push_back(rand_word(span, (i % 64 == 0) || ($urandom_range(0, 40) == 0)));
    end
    send_hold = 1'b0;
  endtask

  initial begin
    in_word_t d;
    lr_q = LrReset; b1_q = B1Reset; b2_q = B2Reset; eps_q = EpsReset;
    steps_q = 0; p1_q = 32'hFFFF_FFFF; p2_q = 32'hFFFF_FFFF;
    for (int i = 0; i < Depth; i++) begin m_store[i] = 0; v_store[i] = 0; end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: before any step, extremes, repeated index, fresh step
    d = '0;
    d.gradient = 32'sh7FFF_FFFF; d.weight_in = 32'sh8000_0000; pending_words.push_back(d);
    d.gradient = 32'sh8000_0000; d.weight_in = 32'sh7FFF_FFFF; pending_words.push_back(d);
    d.param_index = 12'hFFF; d.gradient = 0; d.weight_in = 0; pending_words.push_back(d);
    d.param_index = 12'd5; d.gradient = 32'sh0100_0000; pending_words.push_back(d);
    d.new_step = 1; pending_words.push_back(d);
    d.new_step = 0; d.gradient = -32'sh0100_0000; pending_words.push_back(d);
    d.param_index = 12'hFFF; d.new_step = 1; d.gradient = 32'sh8000_0000;
    pending_words.push_back(d);
    send_hold = 1'b0;
    drain();

    write_reg(CFG_LR, 24'hFF_FFFF);
    write_reg(CFG_B1, 16'd0);
    write_reg(CFG_B2, 16'hFFFF);
    write_reg(CFG_EPS, 16'd0);
    for (int i = 0; i < 10; i++) pending_words.push_back(rand_word(3, i < 3));
    send_hold = 1'b0;
    drain();

    write_reg(CFG_B1, 16'hFFFF);
    write_reg(CFG_B2, 16'd0);
    write_reg(CFG_EPS, 16'hFFFF);
    write_reg(CFG_LR, 24'd0);
    random_phase(300);
    // long receiver hold-off while words keep coming
    hold_req = 1'b1;
    wait (hold_done);
    drain();

    write_reg(CFG_LR, LrReset);
    write_reg(CFG_B1, B1Reset);
    write_reg(CFG_B2, B2Reset);
    write_reg(CFG_EPS, EpsReset);
    random_phase(900);
    drain();

    write_reg(CFG_LR, 24'($urandom));
    write_reg(CFG_B1, 16'($urandom));
    write_reg(CFG_B2, 16'($urandom));
    write_reg(CFG_EPS, 16'($urandom));
    random_phase(600);
    drain();

    $display("covered %0d words in, %0d results checked, five register settings",
             accepted_in, checked_out);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== adam_weight_update.f =====
hdl/adw_pkg.sv
hdl/adw_moment.sv
hdl/adw_bias.sv
hdl/adw_root.sv
hdl/adw_quot.sv
hdl/adam_weight_update.sv
bench/tb.sv
